@@ hdl/dtw_pkg.sv @@
// dtw_pkg: shared types and constants of the double tap wake detector
// used by dtw_csr and double_tap_wake_detector; no dependencies

package dtw_pkg;

   // configuration register widths
   localparam int RADIUS_W = 12;
   localparam int WINDOW_W = 16;
   localparam int AREA_W   = 12;
   localparam int MODE_W   = 2;
   localparam int OPT_W    = 3;

   // register file geometry
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   // event and result widths
   localparam int KIND_W  = 2;
   localparam int TIME_W  = 32;
   localparam int WAKE_W  = 2;
   localparam int COUNT_W = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TAP_RADIUS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_WINDOW_MS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_LEFT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_RIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_TOP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_BOTTOM   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_MODE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OPTION_BITS   = 3'd7;

   // register reset values
   localparam logic [RADIUS_W-1:0] RST_TAP_RADIUS    = 12'd80;
   localparam logic [WINDOW_W-1:0] RST_TAP_WINDOW_MS = 16'd350;
   localparam logic [AREA_W-1:0]   RST_AREA_LEFT     = 12'd0;
   localparam logic [AREA_W-1:0]   RST_AREA_RIGHT    = 12'd720;
   localparam logic [AREA_W-1:0]   RST_AREA_TOP      = 12'd0;
   localparam logic [AREA_W-1:0]   RST_AREA_BOTTOM   = 12'd1280;
   localparam logic [MODE_W-1:0]   RST_REGION_MODE   = 2'd0;
   localparam logic [OPT_W-1:0]    RST_OPTION_BITS   = 3'd4;

   // option bit positions
   localparam int OPT_INVERT_AREA = 0;
   localparam int OPT_ALLOW_CALL  = 1;
   localparam int OPT_DOUBLE_TAP  = 2;

   // region modes
   localparam logic [MODE_W-1:0] MODE_AREA   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BUTTON = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd2;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_POSITION = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LIFT     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SLOT     = 2'd2;

   // wake codes
   localparam logic [WAKE_W-1:0] WAKE_NONE   = 2'd0;
   localparam logic [WAKE_W-1:0] WAKE_DOUBLE = 2'd1;
   localparam logic [WAKE_W-1:0] WAKE_POCKET = 2'd2;

   // saturation limit of the pocket tap count
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   // live configuration handed from the register file to the datapath
   typedef struct packed {
      logic [RADIUS_W-1:0] tap_radius;
      logic [WINDOW_W-1:0] tap_window_ms;
      logic [AREA_W-1:0]   area_left;
      logic [AREA_W-1:0]   area_right;
      logic [AREA_W-1:0]   area_top;
      logic [AREA_W-1:0]   area_bottom;
      logic [MODE_W-1:0]   region_mode;
      logic [OPT_W-1:0]    option_bits;
   } cfg_type;

endpackage

@@ hdl/dtw_csr.sv @@
// dtw_csr: register file of the double tap wake detector behind an apb style port
// depends on dtw_pkg

module dtw_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dtw_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [dtw_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [dtw_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready,
   output dtw_pkg::cfg_type                     cfg
);

   dtw_pkg::cfg_type                cfg_ff;
   logic                            wr_en;
   logic [dtw_pkg::CSR_IDX_W-1:0]   idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign idx    = paddr[dtw_pkg::CSR_ADDR_W-1:2];
   assign cfg    = cfg_ff;

   // register writes on the access phase of a write transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_radius    <= dtw_pkg::RST_TAP_RADIUS;
         cfg_ff.tap_window_ms <= dtw_pkg::RST_TAP_WINDOW_MS;
         cfg_ff.area_left     <= dtw_pkg::RST_AREA_LEFT;
         cfg_ff.area_right    <= dtw_pkg::RST_AREA_RIGHT;
         cfg_ff.area_top      <= dtw_pkg::RST_AREA_TOP;
         cfg_ff.area_bottom   <= dtw_pkg::RST_AREA_BOTTOM;
         cfg_ff.region_mode   <= dtw_pkg::RST_REGION_MODE;
         cfg_ff.option_bits   <= dtw_pkg::RST_OPTION_BITS;
      end else if (wr_en) begin
         case (idx)
            dtw_pkg::REG_TAP_RADIUS:    cfg_ff.tap_radius    <= pwdata[dtw_pkg::RADIUS_W-1:0];
            dtw_pkg::REG_TAP_WINDOW_MS: cfg_ff.tap_window_ms <= pwdata[dtw_pkg::WINDOW_W-1:0];
            dtw_pkg::REG_AREA_LEFT:     cfg_ff.area_left     <= pwdata[dtw_pkg::AREA_W-1:0];
            dtw_pkg::REG_AREA_RIGHT:    cfg_ff.area_right    <= pwdata[dtw_pkg::AREA_W-1:0];
            dtw_pkg::REG_AREA_TOP:      cfg_ff.area_top      <= pwdata[dtw_pkg::AREA_W-1:0];
            dtw_pkg::REG_AREA_BOTTOM:   cfg_ff.area_bottom   <= pwdata[dtw_pkg::AREA_W-1:0];
            dtw_pkg::REG_REGION_MODE:   cfg_ff.region_mode   <= pwdata[dtw_pkg::MODE_W-1:0];
            dtw_pkg::REG_OPTION_BITS:   cfg_ff.option_bits   <= pwdata[dtw_pkg::OPT_W-1:0];
            default: ;
         endcase
      end
   end

   // read back, zero extended
   always_comb begin
      case (idx)
         dtw_pkg::REG_TAP_RADIUS:    prdata = dtw_pkg::CSR_DATA_W'(cfg_ff.tap_radius);
         dtw_pkg::REG_TAP_WINDOW_MS: prdata = dtw_pkg::CSR_DATA_W'(cfg_ff.tap_window_ms);
         dtw_pkg::REG_AREA_LEFT:     prdata = dtw_pkg::CSR_DATA_W'(cfg_ff.area_left);
         dtw_pkg::REG_AREA_RIGHT:    prdata = dtw_pkg::CSR_DATA_W'(cfg_ff.area_right);
         dtw_pkg::REG_AREA_TOP:      prdata = dtw_pkg::CSR_DATA_W'(cfg_ff.area_top);
         dtw_pkg::REG_AREA_BOTTOM:   prdata = dtw_pkg::CSR_DATA_W'(cfg_ff.area_bottom);
         dtw_pkg::REG_REGION_MODE:   prdata = dtw_pkg::CSR_DATA_W'(cfg_ff.region_mode);
         dtw_pkg::REG_OPTION_BITS:   prdata = dtw_pkg::CSR_DATA_W'(cfg_ff.option_bits);
         default:                    prdata = '0;
      endcase
   end

endmodule

@@ hdl/double_tap_wake_detector.sv @@
// double_tap_wake_detector: top level of the double tap / pocket wake gesture detector
// depends on dtw_pkg and dtw_csr
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_kind req_pos_x req_pos_y req_time_ms
//                                               req_screen_off req_in_call req_pocketed
//   rsp       out        rsp_valid / rsp_stall  rsp_wake
//   csr       in/out     psel penable pwrite    paddr pwdata prdata pready
//
// one transaction per cycle sustained while the result register is not stalled
// an input register holds the event, the gesture state and result register update together
// reset (synchronous) clears the gesture state, sets the lift flag and loads register defaults
// req_stall rises only while the input register is full and the result register is stalled

module double_tap_wake_detector #(
   parameter int POCKET_TAPS      = 4,
   parameter int POCKET_WINDOW_MS = 550,
   parameter int BUTTON_ROW_Y     = 1920,
   parameter int POCKET_ROW_LIMIT = 1280,
   parameter int COORD_BITS       = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input transactions
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dtw_pkg::KIND_W-1:0]           req_kind,
   input  logic [COORD_BITS-1:0]                req_pos_x,
   input  logic [COORD_BITS-1:0]                req_pos_y,
   input  logic [dtw_pkg::TIME_W-1:0]           req_time_ms,
   input  logic                                 req_screen_off,
   input  logic                                 req_in_call,
   input  logic                                 req_pocketed,
   // result transactions
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dtw_pkg::WAKE_W-1:0]           rsp_wake,
   // configuration
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dtw_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [dtw_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [dtw_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);

   // compare widths: coordinates against 12 bit registers, squared distance
   localparam int AW   = (COORD_BITS > dtw_pkg::AREA_W) ? COORD_BITS : dtw_pkg::AREA_W;
   localparam int SQ_W = (2 * COORD_BITS + 1 > 2 * dtw_pkg::RADIUS_W) ?
                         2 * COORD_BITS + 1 : 2 * dtw_pkg::RADIUS_W;

   dtw_pkg::cfg_type cfg;

   dtw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register
   logic                           s1_valid_ff;
   logic [dtw_pkg::KIND_W-1:0]     s1_kind_ff;
   logic [COORD_BITS-1:0]          s1_x_ff;
   logic [COORD_BITS-1:0]          s1_y_ff;
   logic [dtw_pkg::TIME_W-1:0]     s1_time_ff;
   logic                           s1_screen_off_ff;
   logic                           s1_in_call_ff;
   logic                           s1_pocketed_ff;

   // gesture state
   logic                           first_seen_ff, first_seen_in;
   logic [dtw_pkg::TIME_W-1:0]     first_time_ff, first_time_in;
   logic [COORD_BITS-1:0]          first_x_ff, first_x_in;
   logic [COORD_BITS-1:0]          first_y_ff, first_y_in;
   logic                           lifted_ff, lifted_in;
   logic [dtw_pkg::COUNT_W-1:0]    pocket_cnt_ff, pocket_cnt_in;
   logic [dtw_pkg::TIME_W-1:0]     pocket_start_ff, pocket_start_in;

   // result register
   logic                           rsp_valid_ff;
   logic [dtw_pkg::WAKE_W-1:0]     rsp_wake_ff;
   logic [dtw_pkg::WAKE_W-1:0]     wake_in;

   logic                           s1_adv;
   logic                           req_take;

   // stage advance: result register empty or being drained
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_wake  = rsp_wake_ff;

   // datapath signals
   logic                           gated;
   logic [AW-1:0]                  xa, ya;
   logic                           button_hit, area_mode, in_area, region_hit;
   logic [COORD_BITS-1:0]          dx, dy;
   logic [SQ_W-1:0]                dist_sq, radius_sq;
   logic                           close_enough, in_window;
   logic [dtw_pkg::TIME_W-1:0]     tap_elapsed, pocket_elapsed;
   logic [dtw_pkg::COUNT_W-1:0]    cnt_inc;

   // region qualification
   always_comb begin
      xa         = AW'(s1_x_ff);
      ya         = AW'(s1_y_ff);
      button_hit = (cfg.region_mode == dtw_pkg::MODE_BUTTON ||
                    cfg.region_mode == dtw_pkg::MODE_BOTH) && (ya > AW'(BUTTON_ROW_Y));
      area_mode  = (cfg.region_mode == dtw_pkg::MODE_AREA ||
                    cfg.region_mode == dtw_pkg::MODE_BOTH);
      if (!cfg.option_bits[dtw_pkg::OPT_INVERT_AREA]) begin
         in_area = xa >= AW'(cfg.area_left) && xa <= AW'(cfg.area_right) &&
                   ya >= AW'(cfg.area_top) && ya <= AW'(cfg.area_bottom);
      end else begin
         in_area = xa <= AW'(cfg.area_left) || xa >= AW'(cfg.area_right) ||
                   ya <= AW'(cfg.area_top) || ya >= AW'(cfg.area_bottom);
      end
      region_hit = button_hit || (area_mode && in_area);
   end

   // distance and timing tests against the first tap
   always_comb begin
      dx           = (s1_x_ff > first_x_ff) ? s1_x_ff - first_x_ff : first_x_ff - s1_x_ff;
      dy           = (s1_y_ff > first_y_ff) ? s1_y_ff - first_y_ff : first_y_ff - s1_y_ff;
      dist_sq      = SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
      radius_sq    = SQ_W'(cfg.tap_radius) * SQ_W'(cfg.tap_radius);
      close_enough = dist_sq < radius_sq;
      tap_elapsed  = s1_time_ff - first_time_ff;
      in_window    = tap_elapsed < dtw_pkg::TIME_W'(cfg.tap_window_ms);
      pocket_elapsed = s1_time_ff - pocket_start_ff;
      cnt_inc      = (pocket_cnt_ff < dtw_pkg::COUNT_MAX) ? pocket_cnt_ff + 1'b1 : pocket_cnt_ff;
   end

   // next gesture state and result for the transaction in the input register
   always_comb begin
      first_seen_in   = first_seen_ff;
      first_time_in   = first_time_ff;
      first_x_in      = first_x_ff;
      first_y_in      = first_y_ff;
      lifted_in       = lifted_ff;
      pocket_cnt_in   = pocket_cnt_ff;
      pocket_start_in = pocket_start_ff;
      wake_in         = dtw_pkg::WAKE_NONE;
      gated = (s1_in_call_ff && !cfg.option_bits[dtw_pkg::OPT_ALLOW_CALL]) || !s1_screen_off_ff;
      if (!gated) begin
         case (s1_kind_ff)
            dtw_pkg::KIND_SLOT: begin
               first_seen_in = 1'b0;
               first_time_in = '0;
               first_x_in    = '0;
               first_y_in    = '0;
            end
            dtw_pkg::KIND_LIFT: begin
               lifted_in = 1'b1;
            end
            dtw_pkg::KIND_POSITION: begin
               if (s1_pocketed_ff) begin
                  // pocket mode: count taps near the top
                  if (lifted_ff && (AW'(s1_y_ff) < AW'(POCKET_ROW_LIMIT))) begin
                     lifted_in     = 1'b0;
                     pocket_cnt_in = cnt_inc;
                     if (cnt_inc == dtw_pkg::COUNT_W'(1)) begin
                        pocket_start_in = s1_time_ff;
                     end else if (cnt_inc == dtw_pkg::COUNT_W'(POCKET_TAPS) &&
                                  pocket_elapsed < dtw_pkg::TIME_W'(POCKET_WINDOW_MS)) begin
                        wake_in         = dtw_pkg::WAKE_POCKET;
                        pocket_cnt_in   = '0;
                        pocket_start_in = '0;
                     end else if (pocket_elapsed > dtw_pkg::TIME_W'(POCKET_WINDOW_MS)) begin
                        pocket_cnt_in = '0;
                     end
                  end
               end else begin
                  pocket_cnt_in = '0;
                  // double tap: second tap close in space and time
                  if (region_hit && lifted_ff) begin
                     lifted_in = 1'b0;
                     if (first_seen_ff && close_enough && in_window &&
                         cfg.option_bits[dtw_pkg::OPT_DOUBLE_TAP]) begin
                        wake_in       = dtw_pkg::WAKE_DOUBLE;
                        first_seen_in = 1'b0;
                        first_time_in = '0;
                        first_x_in    = '0;
                        first_y_in    = '0;
                     end else begin
                        first_seen_in = 1'b1;
                        first_time_in = s1_time_ff;
                        first_x_in    = s1_x_ff;
                        first_y_in    = s1_y_ff;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_take) begin
         s1_kind_ff       <= req_kind;
         s1_x_ff          <= req_pos_x;
         s1_y_ff          <= req_pos_y;
         s1_time_ff       <= req_time_ms;
         s1_screen_off_ff <= req_screen_off;
         s1_in_call_ff    <= req_in_call;
         s1_pocketed_ff   <= req_pocketed;
      end
   end

   // gesture state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff   <= 1'b0;
         first_time_ff   <= '0;
         first_x_ff      <= '0;
         first_y_ff      <= '0;
         lifted_ff       <= 1'b1;
         pocket_cnt_ff   <= '0;
         pocket_start_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (s1_adv) begin
            first_seen_ff   <= first_seen_in;
            first_time_ff   <= first_time_in;
            first_x_ff      <= first_x_in;
            first_y_ff      <= first_y_in;
            lifted_ff       <= lifted_in;
            pocket_cnt_ff   <= pocket_cnt_in;
            pocket_start_ff <= pocket_start_in;
            rsp_valid_ff    <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff    <= 1'b0;
         end
      end
      if (s1_adv) begin
         rsp_wake_ff <= wake_in;
      end
   end

`ifndef SYNTHESIS
   // a pocket wake empties the tap count
   a_pocket_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && wake_in == dtw_pkg::WAKE_POCKET) |=> (pocket_cnt_ff == '0))
      else $error("pocket wake did not clear the tap count");

   // a double tap wake forgets the first tap
   a_double_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && wake_in == dtw_pkg::WAKE_DOUBLE) |=> !first_seen_ff)
      else $error("double tap wake left a first tap behind");

   // a gated event leaves the gesture state alone
   a_gated_stable: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && gated) |=> ($stable(first_seen_ff) && $stable(lifted_ff) &&
                             $stable(pocket_cnt_ff)))
      else $error("gated event changed the gesture state");

   // a held transaction is not dropped from the input register
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("stalled transaction lost from the input register");

   // a wake is only reported for a lift-qualified tap
   a_wake_needs_lift: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && wake_in != dtw_pkg::WAKE_NONE) |-> lifted_ff)
      else $error("wake without a preceding contact lift");
`endif

endmodule
